/* src/lts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LBA to CHS track splitter package
// Shared widths, register indexes, geometry limits and the job record
// handed from the front end to the chunk sequencer.
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int LBA_W     = 24;
  localparam int COUNT_W   = 8;
  localparam int SPT_W     = 6;
  localparam int HEADS_W   = 5;
  localparam int HEAD_W    = 4;
  localparam int CYL_OUT_W = 8;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 6;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  localparam int DIV_BITS  = 2;
  localparam int DIV_STEPS = LBA_W / DIV_BITS;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_SPT   = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_HEADS = CFG_ADDR_W'(1);

  localparam logic [SPT_W-1:0]   SPT_RESET   = SPT_W'(18);
  localparam logic [HEADS_W-1:0] HEADS_RESET = HEADS_W'(2);
  localparam logic [SPT_W-1:0]   SPT_MIN     = SPT_W'(8);
  localparam logic [HEADS_W-1:0] HEADS_MIN   = HEADS_W'(1);
  localparam logic [HEADS_W-1:0] HEADS_MAX   = HEADS_W'(16);

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV_SPT,
    F_DIV_HEADS,
    F_PUSH
  } front_state_t;

  typedef struct packed {
    logic               dir;
    logic [LBA_W-1:0]   cyl;
    logic [HEAD_W-1:0]  hd;
    logic [SPT_W-1:0]   sec0;
    logic [COUNT_W-1:0] count;
    logic [SPT_W-1:0]   spt;
    logic [HEADS_W-1:0] heads;
  } job_t;

endpackage

/* src/lts_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division of a 24-bit address by a 6-bit divisor, two quotient
// bits per cycle; done is registered together with the final quotient and remainder.
// ----------------------------------------------------------------------------
module lts_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [lts_pkg::LBA_W-1:0]    dividend,
  input  logic [lts_pkg::SPT_W-1:0]    divisor,
  output logic                         done,
  output logic [lts_pkg::LBA_W-1:0]    quotient,
  output logic [lts_pkg::SPT_W-1:0]    remainder
);

  localparam int CNT_W = $clog2(lts_pkg::DIV_STEPS);

  logic                        busy_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [lts_pkg::LBA_W-1:0]   quo_r;
  logic [lts_pkg::LBA_W-1:0]   quo_nxt;
  logic [lts_pkg::SPT_W-1:0]   rem_r;
  logic [lts_pkg::SPT_W-1:0]   rem_nxt;
  logic [lts_pkg::SPT_W-1:0]   div_r;

  always_comb begin
    logic [lts_pkg::SPT_W:0] trial;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    for (int k = 0; k < lts_pkg::DIV_BITS; k++) begin
      trial = {rem_nxt, quo_nxt[lts_pkg::LBA_W-1]};
      if (trial >= {1'b0, div_r}) begin
        trial   = trial - {1'b0, div_r};
        rem_nxt = trial[lts_pkg::SPT_W-1:0];
        quo_nxt = {quo_nxt[lts_pkg::LBA_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[lts_pkg::SPT_W-1:0];
        quo_nxt = {quo_nxt[lts_pkg::LBA_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(lts_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* src/lts_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request front end
// Accept a request, convert its start address to cylinder, head and sector
// on the shared divider, and push the job into the queue.
// ----------------------------------------------------------------------------
module lts_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lts_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                            in_tuser,
  input  logic [lts_pkg::SPT_W-1:0]       spt_eff,
  input  logic [lts_pkg::HEADS_W-1:0]     heads_eff,
  output logic                            div_start,
  output logic [lts_pkg::LBA_W-1:0]       div_dividend,
  output logic [lts_pkg::SPT_W-1:0]       div_divisor,
  input  logic                            div_done,
  input  logic [lts_pkg::LBA_W-1:0]       div_quotient,
  input  logic [lts_pkg::SPT_W-1:0]       div_remainder,
  output logic                            q_push,
  output lts_pkg::job_t                   q_job,
  input  logic                            q_full
);

  lts_pkg::front_state_t state_r;
  lts_pkg::front_state_t state_nxt;
  lts_pkg::job_t         job_r;
  lts_pkg::job_t         job_nxt;
  logic [lts_pkg::LBA_W-1:0]   in_lba;
  logic [lts_pkg::COUNT_W-1:0] in_count;

  assign in_lba   = in_tdata[lts_pkg::LBA_W-1:0];
  assign in_count = in_tdata[lts_pkg::LBA_W +: lts_pkg::COUNT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lts_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    job_nxt      = job_r;
    in_tready    = 1'b0;
    div_start    = 1'b0;
    div_dividend = div_quotient;
    div_divisor  = {1'b0, job_r.heads};
    q_push       = 1'b0;
    case (state_r)
      lts_pkg::F_IDLE: begin
        in_tready    = 1'b1;
        div_dividend = in_lba;
        div_divisor  = spt_eff;
        if (in_tvalid && in_count != '0) begin
          div_start     = 1'b1;
          job_nxt.dir   = in_tuser;
          job_nxt.count = in_count;
          job_nxt.spt   = spt_eff;
          job_nxt.heads = heads_eff;
          state_nxt     = lts_pkg::F_DIV_SPT;
        end
      end
      lts_pkg::F_DIV_SPT: begin
        if (div_done) begin
          div_start    = 1'b1;
          job_nxt.sec0 = div_remainder;
          state_nxt    = lts_pkg::F_DIV_HEADS;
        end
      end
      lts_pkg::F_DIV_HEADS: begin
        if (div_done) begin
          job_nxt.hd  = div_remainder[lts_pkg::HEAD_W-1:0];
          job_nxt.cyl = div_quotient;
          state_nxt   = lts_pkg::F_PUSH;
        end
      end
      lts_pkg::F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = lts_pkg::F_IDLE;
        end
      end
      default: begin
        state_nxt = lts_pkg::F_IDLE;
      end
    endcase
  end

  assign q_job = job_r;

endmodule

/* src/lts_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue
// Small register FIFO of converted jobs between front end and sequencer.
// ----------------------------------------------------------------------------
module lts_queue #(
  parameter int DEPTH = lts_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lts_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output lts_pkg::job_t pop_data,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lts_pkg::job_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/lts_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk sequencer
// Walk a job track by track and emit one controller command per track
// through a registered output stage.
// ----------------------------------------------------------------------------
module lts_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  output logic                             q_pop,
  input  lts_pkg::job_t                    q_job,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lts_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tuser,
  output logic                             out_tlast
);

  logic                          busy_r;
  lts_pkg::job_t                 cur_r;
  logic [lts_pkg::COUNT_W-1:0]   off_r;
  logic                          out_valid_r;
  logic [lts_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                          out_dir_r;
  logic                          out_last_r;

  logic [lts_pkg::SPT_W-1:0]     room;
  logic [lts_pkg::SPT_W-1:0]     chunk;
  logic [lts_pkg::COUNT_W-1:0]   rem_left;
  logic [lts_pkg::HEADS_W-1:0]   hd_inc;
  logic                          emit;
  logic                          load;
  logic                          ovf;

  assign room     = cur_r.spt - cur_r.sec0;
  assign chunk    = (cur_r.count < {2'b00, room}) ? cur_r.count[lts_pkg::SPT_W-1:0] : room;
  assign rem_left = cur_r.count - {2'b00, chunk};
  assign hd_inc   = {1'b0, cur_r.hd} + lts_pkg::HEADS_W'(1);
  assign ovf      = |cur_r.cyl[lts_pkg::LBA_W-1:lts_pkg::CYL_OUT_W];
  assign emit     = busy_r && (!out_valid_r || out_tready);
  assign load     = !busy_r && !q_empty;
  assign q_pop    = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
      end else if (emit && rem_left == '0) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_job;
      off_r <= '0;
    end else if (emit) begin
      cur_r.count <= rem_left;
      cur_r.sec0  <= '0;
      off_r       <= off_r + {2'b00, chunk};
      if (hd_inc == cur_r.heads) begin
        cur_r.hd  <= '0;
        cur_r.cyl <= cur_r.cyl + lts_pkg::LBA_W'(1);
      end else begin
        cur_r.hd <= hd_inc[lts_pkg::HEAD_W-1:0];
      end
    end
    if (emit) begin
      out_dir_r  <= cur_r.dir;
      out_last_r <= (rem_left == '0);
      out_data_r <= {7'b0, ovf, off_r, chunk, cur_r.sec0 + lts_pkg::SPT_W'(1),
                     cur_r.hd, cur_r.cyl[lts_pkg::CYL_OUT_W-1:0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_dir_r;
  assign out_tlast  = out_last_r;

endmodule

/* src/lba_to_chs_track_splitter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LBA to CHS track splitter
// Split a disk request into per-track cylinder/head/sector commands.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per transfer; tuser is the direction (0 read,
//           1 write), tdata holds start LBA and sector count.
//   out_* : one command per track touched; tlast marks the final command
//           of a request. A zero sector count yields no commands.
//   cfg_* : write sectors_per_track (index 0) or head_count (index 1)
//           while the block is idle. Values outside the supported range
//           are clamped when used.
// Conversion: the front end converts the start address with two passes over
//   one 2-bit-per-step divider, by sectors per track and then by heads,
//   before its job enters the queue; the sequencer then loads the job and
//   emits one command per cycle through its output register while the
//   receiver keeps out_tready high. The front end converts one request at
//   a time; a two-entry job queue lets it convert the next request while
//   commands of earlier ones are still going out.
// Reset: geometry returns to 18 sectors and 2 heads; queue and output
//   stage empty. A stalled receiver holds the output register, then the
//   sequencer, then the queue, and finally in_tready drops.
// ----------------------------------------------------------------------------
module lba_to_chs_track_splitter_top #(
  parameter int QUEUE_DEPTH = lts_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [23:0] start_lba, [31:24] sector_count
  input  logic [lts_pkg::IN_DATA_W-1:0]      in_tdata,
  // [0] action
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] cylinder, [11:8] head, [17:12] first_sector, [23:18] chunk_sectors,
  // [31:24] buffer_offset, [32] cylinder_overflow, [39:33] zero
  output logic [lts_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [0] direction
  output logic                               out_tuser,
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [lts_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [lts_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [lts_pkg::SPT_W-1:0]   spt_r;
  logic [lts_pkg::HEADS_W-1:0] heads_r;
  logic [lts_pkg::SPT_W-1:0]   spt_eff;
  logic [lts_pkg::HEADS_W-1:0] heads_eff;

  logic                        div_start;
  logic [lts_pkg::LBA_W-1:0]   div_dividend;
  logic [lts_pkg::SPT_W-1:0]   div_divisor;
  logic                        div_done;
  logic [lts_pkg::LBA_W-1:0]   div_quotient;
  logic [lts_pkg::SPT_W-1:0]   div_remainder;

  logic                        q_push;
  logic                        q_pop;
  logic                        q_full;
  logic                        q_empty;
  lts_pkg::job_t               q_in_job;
  lts_pkg::job_t               q_out_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r   <= lts_pkg::SPT_RESET;
      heads_r <= lts_pkg::HEADS_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        lts_pkg::REG_SPT:   spt_r   <= cfg_wdata[lts_pkg::SPT_W-1:0];
        lts_pkg::REG_HEADS: heads_r <= cfg_wdata[lts_pkg::HEADS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign spt_eff   = (spt_r < lts_pkg::SPT_MIN) ? lts_pkg::SPT_MIN : spt_r;
  assign heads_eff = (heads_r < lts_pkg::HEADS_MIN) ? lts_pkg::HEADS_MIN :
                     (heads_r > lts_pkg::HEADS_MAX) ? lts_pkg::HEADS_MAX : heads_r;

  lts_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  lts_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .spt_eff       (spt_eff),
    .heads_eff     (heads_eff),
    .div_start     (div_start),
    .div_dividend  (div_dividend),
    .div_divisor   (div_divisor),
    .div_done      (div_done),
    .div_quotient  (div_quotient),
    .div_remainder (div_remainder),
    .q_push        (q_push),
    .q_job         (q_in_job),
    .q_full        (q_full)
  );

  lts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out_job),
    .empty     (q_empty)
  );

  lts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_job      (q_out_job),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
